/* rtl/bctg_pkg.sv */
// shared constants and types for the beep cadence tone generator
// no dependencies; used by bctg_div and beep_cadence_tone_generator
package bctg_pkg;

	localparam int CLOCK_HZ       = 16000000;
	localparam int VOLUME_DIVISOR = 2;

	// dividend width covers the clock constant, divisor width covers a 16-bit field
	localparam int DIV_W = $clog2(CLOCK_HZ + 1);
	localparam int DEN_W = 16;
	localparam int CNT_W = $clog2(DIV_W + 1);

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/bctg_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on bctg_pkg
module bctg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bctg_pkg::div_req_t req,
	output bctg_pkg::div_rsp_t rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [bctg_pkg::CNT_W-1:0] cnt_q;
	logic [bctg_pkg::DEN_W-1:0] rem_q;
	logic [bctg_pkg::DIV_W-1:0] quo_q;
	logic [bctg_pkg::DEN_W-1:0] den_q;
	logic [bctg_pkg::DEN_W:0]   trial;
	logic                       fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[bctg_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= bctg_pkg::CNT_W'(bctg_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bctg_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? bctg_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[bctg_pkg::DEN_W-1:0];
			quo_q <= {quo_q[bctg_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q && !done_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == bctg_pkg::CNT_W'(1) && !req.start) |=> done_q)
		else $error("divider missed its done pulse");

endmodule

/* rtl/beep_cadence_tone_generator.sv */
// top level of the beep cadence tone generator: command decode, cadence state, output register
// depends on bctg_pkg and bctg_div
//
// Each request on the slave stream is one command (tick, set, start or stop) and produces
// exactly one result on the master stream: tone on/off, timer top, duty compare and the
// running flag, all taken after the command has been applied. Commands that leave the tone
// period alone go straight to the done state and load the result register there once the
// output register is free. Commands that recompute the period (a tick that ends a mute phase,
// or a set while a beep phase is counting) run the shared one-bit-per-cycle divider once for
// CLOCK_HZ / frequency, DIV_W steps (DIV_W = bits of CLOCK_HZ, 24 at 16 MHz); the duty compare
// is the saturated top divided by the power-of-two VOLUME_DIVISOR, a plain shift. The quotient
// loads the timer top and duty compare, then the result register loads from the done state.
// The slave side is not ready while a command is in work; a finished result waits in the
// output register without holding up the next request, but a second finished result waits
// for that register to empty.
module beep_cadence_tone_generator (
	input  logic        clk,
	input  logic        arst_n,
	// command request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // frequency[15:0], beep_length[31:16], mute_length[47:32]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // tone_on[0], period_top[16:1], duty_compare[32:17],
	                              // is_running[33], zero fill[39:34]
);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;  // clock / frequency
	localparam logic [1:0] ST_DONE = 2'd3;  // hand result to output register

	logic [1:0]  state_q;

	// cadence state
	logic        running_q;
	logic [15:0] beep_count_q;
	logic [15:0] mute_count_q;
	logic [15:0] beep_reload_q;
	logic [15:0] mute_reload_q;
	logic [15:0] tone_freq_q;
	logic        output_on_q;
	logic [15:0] top_value_q;
	logic [15:0] compare_value_q;

	// output register
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	// request fields
	logic [1:0]  cmd;
	logic [15:0] frequency;
	logic [15:0] beep_length;
	logic [15:0] mute_length;
	logic        accept;
	logic        need_period;
	logic        out_load;

	bctg_pkg::div_req_t div_req;
	bctg_pkg::div_rsp_t div_rsp;

	logic [bctg_pkg::DIV_W-1:0] half_quo;
	logic [15:0]                top_next;

	assign cmd         = s_tuser;
	assign frequency   = s_tdata[15:0];
	assign beep_length = s_tdata[31:16];
	assign mute_length = s_tdata[47:32];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// period recompute: tick closing the mute phase, or set during a beep phase
	always_comb begin
		need_period = 1'b0;
		case (cmd)
			bctg_pkg::CMD_TICK:
				need_period = running_q && (beep_count_q == '0) && (mute_count_q == 16'd1);
			bctg_pkg::CMD_SET:
				need_period = (beep_count_q != '0);
			default:
				need_period = 1'b0;
		endcase
	end

	// divide by two, subtract one, saturate to 16 bits, never wrap below zero
	assign half_quo = div_rsp.quotient >> 1;
	always_comb begin
		if (half_quo == '0) begin
			top_next = '0;
		end else if (half_quo > bctg_pkg::DIV_W'(65536)) begin
			top_next = 16'hFFFF;
		end else begin
			top_next = 16'(half_quo - 1'b1);
		end
	end

	// the pass takes the new frequency on a set, the stored one on a tick
	always_comb begin
		div_req.start    = accept && need_period;
		div_req.dividend = bctg_pkg::DIV_W'(bctg_pkg::CLOCK_HZ);
		div_req.divisor  = (cmd == bctg_pkg::CMD_SET) ? frequency : tone_freq_q;
	end

	bctg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= need_period ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cadence counters and settings, applied when the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q       <= 1'b0;
			beep_count_q    <= '0;
			mute_count_q    <= '0;
			beep_reload_q   <= '0;
			mute_reload_q   <= '0;
			tone_freq_q     <= '0;
			output_on_q     <= 1'b0;
			top_value_q     <= '0;
			compare_value_q <= '0;
		end else begin
			if (accept) begin
				case (cmd)
					bctg_pkg::CMD_TICK: begin
						if (running_q) begin
							if (beep_count_q != '0) begin
								// end of beep phase mutes and loads the mute length
								if (beep_count_q == 16'd1) begin
									output_on_q  <= 1'b0;
									mute_count_q <= mute_reload_q;
								end
								beep_count_q <= beep_count_q - 1'b1;
							end else if (mute_count_q != '0) begin
								// end of mute phase unmutes and reloads the beep length
								if (mute_count_q == 16'd1) begin
									output_on_q  <= 1'b1;
									beep_count_q <= beep_reload_q;
								end
								mute_count_q <= mute_count_q - 1'b1;
							end else begin
								beep_count_q <= beep_reload_q;
							end
						end
					end
					bctg_pkg::CMD_SET: begin
						tone_freq_q   <= frequency;
						beep_reload_q <= beep_length;
						mute_reload_q <= mute_length;
						// clamp running counters to the new lengths
						if (beep_count_q > beep_length) begin
							beep_count_q <= beep_length;
						end
						if (mute_count_q > mute_length) begin
							mute_count_q <= mute_length;
						end
					end
					bctg_pkg::CMD_START: begin
						if (!running_q) begin
							beep_count_q <= '0;
							mute_count_q <= 16'd1;
							running_q    <= 1'b1;
						end
					end
					default: begin
						// stop
						if (running_q) begin
							output_on_q <= 1'b0;
						end
						running_q <= 1'b0;
					end
				endcase
			end
			// duty compare is the top over a power-of-two divisor
			if (state_q == ST_DIV && div_rsp.done) begin
				top_value_q     <= top_next;
				compare_value_q <= 16'(top_next / bctg_pkg::VOLUME_DIVISOR);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {6'd0, running_q, compare_value_q, top_value_q, output_on_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a taken request always leaves idle
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q != ST_IDLE)
		else $error("request taken but sequencer stayed idle");
	// divider results only show up while the division pass is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider result with no pass pending");
	// a pending result is never overwritten by the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !out_load)
		else $error("output register overwritten");

endmodule

/* tb/sv/tb_top.sv */
// self-checking bench for beep_cadence_tone_generator: directed and random command requests
// with random idling on both streams, a long result hold-off, and an in-bench cadence predictor
// depends on bctg_pkg and the rtl of beep_cadence_tone_generator
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          TARGET_REQS = 525;  // directed part plus about 500 random requests
	localparam int          CALM_TAIL   = 60;   // last requests go through with no idling
	localparam int          DRAIN_WAIT  = 60;   // covers the worst command, a divide pass
	localparam int          HOLD_AT     = 300;  // receiver cycle at which the long hold starts
	localparam int          HOLD_LEN    = 400;

	// one command request as offered on the slave stream
	typedef struct {
		logic [1:0]  cmd;
		logic [15:0] hz;
		logic [15:0] beep_ticks;
		logic [15:0] mute_ticks;
	} tone_cmd_t;

	// one result, laid out as m_tdata[33:0], tone_on in the lowest bit
	typedef struct packed {
		logic        is_running;
		logic [15:0] duty_compare;
		logic [15:0] period_top;
		logic        tone_on;
	} tone_status_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;  // frequency[15:0], beep_length[31:16], mute_length[47:32]
	logic [1:0]  s_tuser  = bctg_pkg::CMD_TICK;  // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;  // tone_on[0], period_top[16:1], duty_compare[32:17], is_running[33]

	beep_cadence_tone_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------------------------------
	// cadence predictor: its own copy of the block state
	// ---------------------------------------------------------------------------------------
	logic        cadence_on  = 1'b0;
	logic [15:0] beep_left   = '0;
	logic [15:0] mute_left   = '0;
	logic [15:0] beep_reload = '0;
	logic [15:0] mute_reload = '0;
	logic [15:0] tone_hz     = '0;
	logic        sounding    = 1'b0;
	logic [15:0] top_now     = '0;
	logic [15:0] cmp_now     = '0;

	int cmd_seen [4];
	int unmute_retimes;
	int set_retimes;
	int saturated_tops;

	// timer top from the tone frequency, saturated to 16 bits; zero frequency saturates too
	function automatic void retime_tone();
		int unsigned clk_hz;
		int unsigned hz;
		int unsigned vol_div;
		int unsigned half_cycles;
		int unsigned top;
		clk_hz  = bctg_pkg::CLOCK_HZ;
		vol_div = bctg_pkg::VOLUME_DIVISOR;
		hz      = tone_hz;
		if (hz == 0) begin
			half_cycles = 32'hFFFF_FFFF;
		end else begin
			half_cycles = (clk_hz / hz) / 2;
		end
		top = (half_cycles == 0) ? 0 : half_cycles - 1;
		if (top > 32'h0000_FFFF) begin
			top = 32'h0000_FFFF;
		end
		if (top == 32'h0000_FFFF) begin
			saturated_tops++;
		end
		top_now = top[15:0];
		cmp_now = 16'(top / vol_div);
	endfunction

	// apply one accepted command and return the result it must produce
	function automatic tone_status_t apply_tone_cmd(tone_cmd_t c);
		tone_status_t r;
		cmd_seen[c.cmd]++;
		case (c.cmd)
			bctg_pkg::CMD_TICK: begin
				// ticks while stopped leave everything alone
				if (cadence_on) begin
					if (beep_left != 0) begin
						// last beep tick mutes and loads the mute phase
						if (beep_left == 1) begin
							sounding  = 1'b0;
							mute_left = mute_reload;
						end
						beep_left--;
					end else if (mute_left != 0) begin
						// last mute tick retimes the tone and unmutes
						if (mute_left == 1) begin
							retime_tone();
							unmute_retimes++;
							sounding  = 1'b1;
							beep_left = beep_reload;
						end
						mute_left--;
					end else begin
						// both phases empty: reload the beep counter, output untouched
						beep_left = beep_reload;
					end
				end
			end
			bctg_pkg::CMD_SET: begin
				tone_hz     = c.hz;
				beep_reload = c.beep_ticks;
				mute_reload = c.mute_ticks;
				// retime only while a beep phase is counting, judged before clamping
				if (beep_left != 0) begin
					retime_tone();
					set_retimes++;
				end
				if (beep_left > c.beep_ticks) begin
					beep_left = c.beep_ticks;
				end
				if (mute_left > c.mute_ticks) begin
					mute_left = c.mute_ticks;
				end
			end
			bctg_pkg::CMD_START: begin
				// a start while running is ignored
				if (!cadence_on) begin
					beep_left  = '0;
					mute_left  = 16'd1;
					cadence_on = 1'b1;
				end
			end
			bctg_pkg::CMD_STOP: begin
				if (cadence_on) begin
					sounding = 1'b0;
				end
				cadence_on = 1'b0;
			end
		endcase
		r.tone_on      = sounding;
		r.period_top   = top_now;
		r.duty_compare = cmp_now;
		r.is_running   = cadence_on;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// request queue, expected results, bookkeeping
	// ---------------------------------------------------------------------------------------
	tone_cmd_t    cmd_backlog[$];
	tone_status_t status_due[$];

	int          total_reqs;
	int          reqs_taken;
	int          results_checked;
	int          mismatches;
	logic        calm = 1'b0;  // set near the end: no idling on either side
	int unsigned cycle_count;

	task automatic flag_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
		mismatches++;
		$display("mismatch %0d at result %0d: %s got %0d expected %0d",
			mismatches, results_checked, what, got, want);
	endtask

	task automatic queue_cmd(input logic [1:0] cmd, input logic [15:0] hz,
			input logic [15:0] beep_ticks, input logic [15:0] mute_ticks);
		tone_cmd_t c;
		c.cmd        = cmd;
		c.hz         = hz;
		c.beep_ticks = beep_ticks;
		c.mute_ticks = mute_ticks;
		cmd_backlog.push_back(c);
	endtask

	// commands other than set ignore the data fields, so those carry noise
	task automatic queue_plain(input logic [1:0] cmd);
		queue_cmd(cmd, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// frequency mix: zero, the low range around saturation, the top value and anything at all
	function automatic logic [15:0] pick_hz();
		case ($urandom_range(0, 5))
			0:       return 16'd0;
			1:       return 16'($urandom_range(1, 130));
			2:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// short phases so the cadence actually turns over, now and then a huge one
	function automatic logic [15:0] pick_len();
		if ($urandom_range(0, 7) == 0) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(0, 4));
	endfunction

	// ---------------------------------------------------------------------------------------
	// driver: offers requests from the backlog, with random gaps of idle cycles
	// ---------------------------------------------------------------------------------------
	tone_cmd_t on_offer;
	int        tx_gap;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				status_due.push_back(apply_tone_cmd(on_offer));
				reqs_taken++;
			end
			// the slot is free unless a request is still waiting for ready
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (!calm && cycle_count[8] && $urandom_range(0, 4) == 0) begin
					tx_gap = $urandom_range(1, 7) - 1;
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					on_offer = cmd_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= on_offer.cmd;
					s_tdata  <= {on_offer.mute_ticks, on_offer.beep_ticks, on_offer.hz};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// receiver: random stall bursts, plus one long hold so the block backs up into s_tready
	// ---------------------------------------------------------------------------------------
	int rx_age;
	int rx_pause;

	always @(posedge clk) begin
		if (arst_n) begin
			rx_age++;
			if (rx_age == HOLD_AT) begin
				rx_pause = HOLD_LEN;
			end else if (rx_pause == 0 && !calm && rx_age[6] && $urandom_range(0, 5) == 0) begin
				rx_pause = $urandom_range(1, 7);
			end
			if (rx_pause != 0) begin
				rx_pause--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// monitor: every accepted result against the oldest expectation, field by field
	// ---------------------------------------------------------------------------------------
	tone_status_t seen;
	tone_status_t want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = tone_status_t'(m_tdata[33:0]);
			if (status_due.size() == 0) begin
				flag_mismatch("unexpected result, raw low bits", m_tdata[15:0], 16'd0);
			end else begin
				want = status_due.pop_front();
				if (seen.tone_on !== want.tone_on) begin
					flag_mismatch("tone_on", 16'(seen.tone_on), 16'(want.tone_on));
				end
				if (seen.period_top !== want.period_top) begin
					flag_mismatch("period_top", seen.period_top, want.period_top);
				end
				if (seen.duty_compare !== want.duty_compare) begin
					flag_mismatch("duty_compare", seen.duty_compare, want.duty_compare);
				end
				if (seen.is_running !== want.is_running) begin
					flag_mismatch("is_running", 16'(seen.is_running), 16'(want.is_running));
				end
			end
			results_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				status_due.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------------------------------
	initial begin
		int         steps;
		int         roll;
		logic [1:0] noise_cmd;

		// directed: commands while stopped
		queue_plain(bctg_pkg::CMD_TICK);                   // tick while stopped is ignored
		queue_plain(bctg_pkg::CMD_STOP);                   // stop while stopped changes nothing
		queue_cmd(bctg_pkg::CMD_SET, 16'd0, 16'd2, 16'd1); // set while stopped, zero frequency
		queue_plain(bctg_pkg::CMD_START);
		queue_plain(bctg_pkg::CMD_START);                  // start while running is ignored
		queue_plain(bctg_pkg::CMD_TICK);                   // mute ends: zero frequency saturates
		queue_cmd(bctg_pkg::CMD_SET, 16'd1, 16'hFFFF, 16'hFFFF); // retime while beeping, lowest hz
		queue_cmd(bctg_pkg::CMD_SET, 16'hFFFF, 16'd1, 16'd0);    // highest hz, beep counter clamped
		queue_plain(bctg_pkg::CMD_TICK);                   // last beep tick mutes
		queue_plain(bctg_pkg::CMD_TICK);                   // both counters empty: beep reload
		queue_plain(bctg_pkg::CMD_TICK);
		queue_cmd(bctg_pkg::CMD_SET, 16'd122, 16'd3, 16'd2); // no beep counting: no retime
		queue_plain(bctg_pkg::CMD_TICK);                   // reload beep from 3
		queue_plain(bctg_pkg::CMD_TICK);
		queue_plain(bctg_pkg::CMD_TICK);
		queue_plain(bctg_pkg::CMD_TICK);                   // beep over, mute 2 loaded
		queue_plain(bctg_pkg::CMD_TICK);
		queue_plain(bctg_pkg::CMD_TICK);                   // unmute at 122 hz, just saturating
		queue_cmd(bctg_pkg::CMD_SET, 16'd123, 16'd0, 16'd0); // retime just below saturation, clamp
		queue_plain(bctg_pkg::CMD_STOP);                   // stop while running mutes
		queue_plain(bctg_pkg::CMD_TICK);
		queue_plain(bctg_pkg::CMD_START);
		queue_plain(bctg_pkg::CMD_TICK);
		queue_cmd(bctg_pkg::CMD_SET, 16'h8000, 16'h5AA5, 16'hA55A);
		queue_plain(bctg_pkg::CMD_STOP);

		// random: mostly start/set/tick cadences with random content, some noise in between
		while (cmd_backlog.size() < TARGET_REQS) begin
			if ($urandom_range(0, 6) == 0) begin
				noise_cmd = 2'($urandom_range(0, 3));
				if (noise_cmd == bctg_pkg::CMD_SET) begin
					queue_cmd(bctg_pkg::CMD_SET, 16'($urandom), 16'($urandom), 16'($urandom));
				end else begin
					queue_plain(noise_cmd);
				end
			end else begin
				queue_plain(bctg_pkg::CMD_START);
				queue_cmd(bctg_pkg::CMD_SET, pick_hz(), pick_len(), pick_len());
				steps = $urandom_range(4, 30);
				repeat (steps) begin
					roll = $urandom_range(0, 99);
					if (roll < 72) begin
						queue_plain(bctg_pkg::CMD_TICK);
					end else if (roll < 86) begin
						queue_cmd(bctg_pkg::CMD_SET, pick_hz(), pick_len(), pick_len());
					end else if (roll < 93) begin
						queue_plain(bctg_pkg::CMD_STOP);
					end else begin
						queue_plain(bctg_pkg::CMD_START);
					end
				end
				if ($urandom_range(0, 1) == 1) begin
					queue_plain(bctg_pkg::CMD_STOP);
				end
			end
		end
		total_reqs = cmd_backlog.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// everything accepted; idling stops for the tail of the run
		while (cmd_backlog.size() != 0 || s_tvalid) begin
			@(negedge clk);
			if (reqs_taken + CALM_TAIL >= total_reqs) begin
				calm = 1'b1;
			end
		end
		while (status_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
		if (status_due.size() != 0) begin
			flag_mismatch("results never delivered", 16'(status_due.size()), 16'd0);
		end

		$display("covered %0d requests: %0d tick, %0d set, %0d start, %0d stop; %0d results checked",
			reqs_taken, cmd_seen[bctg_pkg::CMD_TICK], cmd_seen[bctg_pkg::CMD_SET],
			cmd_seen[bctg_pkg::CMD_START], cmd_seen[bctg_pkg::CMD_STOP], results_checked);
		$display("period retimed %0d times at unmute and %0d times by set, %0d saturated",
			unmute_retimes, set_retimes, saturated_tops);
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
